/* rtl/cascaded_one_pole_filter_unit_assert.svh */
// Assertion macros for the cascaded one-pole filter unit.
`ifndef CASCADED_ONE_POLE_FILTER_UNIT_ASSERT_SVH
`define CASCADED_ONE_POLE_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COPF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/copf_pkg.sv */
// Shared types, constants and functions of the cascaded one-pole filter unit.
package copf_pkg;

   localparam int STAGE_BITS      = 32;
   localparam int COEFF_BITS      = 17;
   localparam int MODE_BITS       = 3;
   localparam int PROD_BITS       = 50;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int DEF_MAX_STAGES  = 8;
   localparam int DEF_SAMPLE_BITS = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUTOFF_COEFF = 2'd1;

   // Mode codes; LP8 and HP8 also bound the lowpass and highpass groups.
   localparam logic [MODE_BITS-1:0] MODE_LP1   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LP2   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LP4   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_LP8   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_HP2   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_HP4   = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_HP8   = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_NOTCH = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mult;
      logic update;
      logic finish;
   } copf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_last;
   } copf_status_type;

   // Number of stages that a mode runs, before the cap by the stage count.
   function automatic int stage_count(input logic [MODE_BITS-1:0] mode);
      int cnt;
      case (mode)
         MODE_LP1:           cnt = 1;
         MODE_LP2, MODE_HP2: cnt = 2;
         MODE_LP8, MODE_HP8: cnt = 8;
         default:            cnt = 4;
      endcase
      return cnt;
   endfunction

   // Index of the last running stage for a mode and a stage count.
   function automatic int last_index(input logic [MODE_BITS-1:0] mode, input int max_stages);
      int cnt;
      cnt = stage_count(mode);
      if (cnt > max_stages) begin
         cnt = max_stages;
      end
      return cnt - 1;
   endfunction

endpackage

/* rtl/copf_ctrl.sv */
// Controller of the cascaded one-pole filter unit: sequences the stages of one request.
module copf_ctrl #(
   parameter int IDX_BITS   = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  copf_pkg::copf_status_type status,
   output copf_pkg::copf_cmd_type  cmd,
   output logic [IDX_BITS-1:0]     stage_idx
);
   import copf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MULT   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } copf_state_type;

   copf_state_type        state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;

   // Next state, stage index and commands.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.is_last) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = IDX_BITS'(idx_ff + 1'b1);
               state_in = ST_MULT;
            end
         end
         ST_FINISH: begin
            // The result register is free or is being emptied this cycle.
            if (!out_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign stage_idx = idx_ff;

endmodule

/* rtl/copf_dp.sv */
// Datapath of the cascaded one-pole filter unit: stage store, shared multiplier, output.
module copf_dp #(
   parameter int MAX_STAGES  = copf_pkg::DEF_MAX_STAGES,
   parameter int SAMPLE_BITS = copf_pkg::DEF_SAMPLE_BITS,
   parameter int IDX_BITS    = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [copf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [copf_pkg::COEFF_BITS-1:0]       csr_data,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  copf_pkg::copf_cmd_type                cmd,
   input  logic [IDX_BITS-1:0]                   stage_idx,
   output copf_pkg::copf_status_type             status,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   output logic                                  rsp_clipped
);
   import copf_pkg::*;

   localparam logic signed [STAGE_BITS+1:0] SMAX =
      (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
   localparam logic signed [STAGE_BITS+1:0] SMIN = -SMAX - 34'sd1;
   localparam logic signed [STAGE_BITS+2:0] STAGE_HI = 35'sd2147483647;
   localparam logic signed [STAGE_BITS+2:0] STAGE_LO = -35'sd2147483648;
   localparam logic signed [PROD_BITS-1:0]  ROUND_HALF = 50'sd32768;

   logic [MODE_BITS-1:0]            mode_ff;
   logic [COEFF_BITS-1:0]           coeff_ff;
   logic signed [STAGE_BITS-1:0]    stage_ff [MAX_STAGES];
   logic signed [STAGE_BITS-1:0]    x_ff, x_in;
   logic signed [STAGE_BITS-1:0]    prev_ff;
   logic signed [STAGE_BITS-1:0]    first_ff;
   logic signed [PROD_BITS-1:0]     prod_ff, prod_in;
   logic                            flag_ff;
   logic signed [SAMPLE_BITS-1:0]   out_sample_ff, out_sample_in;
   logic                            out_clip_ff, out_clip_in;

   logic signed [STAGE_BITS-1:0]    stage_rd;
   logic signed [STAGE_BITS:0]      diff;
   logic signed [COEFF_BITS:0]      coeff_s;
   logic signed [PROD_BITS-1:0]     rounded;
   logic signed [STAGE_BITS+1:0]    delta;
   logic signed [STAGE_BITS+2:0]    acc;
   logic signed [STAGE_BITS-1:0]    stage_new;
   logic                            stage_ovf;
   logic signed [STAGE_BITS+1:0]    y_raw;
   logic [IDX_BITS-1:0]             last_idx;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         coeff_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FILTER_MODE:  mode_ff  <= csr_data[MODE_BITS-1:0];
            CSR_CUTOFF_COEFF: coeff_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Index of the last running stage of the current mode.
   assign last_idx       = IDX_BITS'(last_index(mode_ff, MAX_STAGES));
   assign status.is_last = (stage_idx == last_idx);

   // Multiply step: coefficient times the gap between predecessor and stage.
   assign x_in     = STAGE_BITS'(req_sample_in);
   assign stage_rd = stage_ff[stage_idx];
   assign diff     = (STAGE_BITS+1)'(prev_ff) - (STAGE_BITS+1)'(stage_rd);
   assign coeff_s  = $signed({1'b0, coeff_ff});
   assign prod_in  = diff * coeff_s;

   // Update step: round half up, accumulate and saturate to 32 bits.
   assign rounded = prod_ff + ROUND_HALF;
   assign delta   = (STAGE_BITS+2)'(rounded >>> 16);
   assign acc     = (STAGE_BITS+3)'(stage_rd) + (STAGE_BITS+3)'(delta);
   always_comb begin
      stage_ovf = 1'b1;
      if (acc > STAGE_HI) begin
         stage_new = STAGE_HI[STAGE_BITS-1:0];
      end else if (acc < STAGE_LO) begin
         stage_new = STAGE_LO[STAGE_BITS-1:0];
      end else begin
         stage_new = acc[STAGE_BITS-1:0];
         stage_ovf = 1'b0;
      end
   end

   // Output forming and saturation to the sample width.
   always_comb begin
      if (mode_ff <= MODE_LP8) begin
         y_raw = (STAGE_BITS+2)'(prev_ff);
      end else if (mode_ff <= MODE_HP8) begin
         y_raw = (STAGE_BITS+2)'(x_ff) - (STAGE_BITS+2)'(prev_ff);
      end else begin
         y_raw = (STAGE_BITS+2)'(x_ff) - (STAGE_BITS+2)'(first_ff)
               + (STAGE_BITS+2)'(prev_ff);
      end
      out_clip_in = flag_ff;
      if (y_raw > SMAX) begin
         out_sample_in = SMAX[SAMPLE_BITS-1:0];
         out_clip_in   = 1'b1;
      end else if (y_raw < SMIN) begin
         out_sample_in = SMIN[SAMPLE_BITS-1:0];
         out_clip_in   = 1'b1;
      end else begin
         out_sample_in = y_raw[SAMPLE_BITS-1:0];
      end
   end

   // Stage store, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STAGES; i++) begin
            stage_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         stage_ff[stage_idx] <= stage_new;
      end
   end

   // Working registers of the request in flight and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (cmd.load) begin
         flag_ff <= 1'b0;
      end else if (cmd.update) begin
         flag_ff <= flag_ff | stage_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= x_in;
         prev_ff <= x_in;
      end else if (cmd.update) begin
         prev_ff <= stage_new;
      end
      if (cmd.update && (stage_idx == '0)) begin
         first_ff <= stage_new;
      end
      if (cmd.mult) begin
         prod_ff <= prod_in;
      end
      if (cmd.finish) begin
         out_sample_ff <= out_sample_in;
         out_clip_ff   <= out_clip_in;
      end
   end

   assign rsp_sample_out = out_sample_ff;
   assign rsp_clipped    = out_clip_ff;

endmodule

/* rtl/cascaded_one_pole_filter_unit.sv */
// Top level of the cascaded one-pole filter unit: controller, datapath and checks.
//
// Lowpass, highpass and notch filter built from up to MAX_STAGES one-pole stages
// that share one multiplier. A request runs its n stages one after another, where n
// is the stage count of the mode (1, 2, 4 or 8, capped at MAX_STAGES): each stage
// passes through the multiply step and then the round, accumulate and saturate
// step that writes it back, since the next stage needs the updated value. A new
// request is taken only once the last one has left its finish step. The result
// sits in an output register, so a new request is taken while the last result
// still waits; only a second finished result waits for the first to be taken.
// Configuration writes are always taken (csr_ready is high) and must be made while
// the unit is idle. Stages reset to zero and are kept across mode changes.
`include "cascaded_one_pole_filter_unit_assert.svh"

module cascaded_one_pole_filter_unit #(
   parameter int MAX_STAGES  = copf_pkg::DEF_MAX_STAGES,
   parameter int SAMPLE_BITS = copf_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [copf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [copf_pkg::COEFF_BITS-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_clipped
);
   import copf_pkg::*;

   localparam int IDX_BITS = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

   copf_cmd_type          cmd;
   copf_status_type       status;
   logic [IDX_BITS-1:0]   stage_idx;

   assign csr_ready = 1'b1;

   copf_ctrl #(
      .IDX_BITS   (IDX_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .stage_idx (stage_idx)
   );

   copf_dp #(
      .MAX_STAGES  (MAX_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample_in  (req_sample_in),
      .cmd            (cmd),
      .stage_idx      (stage_idx),
      .status         (status),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

   // An accepted request keeps the input side busy in the next cycle.
   `COPF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "idle after accept")
   // A finished result never overwrites one that is still waiting.
   `COPF_ASSERT_SAME(a_no_overwrite, cmd.finish, !rsp_valid || !rsp_stall, "result overwritten")
   // Every stage write-back follows its multiply cycle.
   `COPF_ASSERT_SAME(a_update_after_mult, cmd.update, $past(cmd.mult), "update without multiply")
   // The stage index is zero when a new request starts its first stage.
   `COPF_ASSERT_NEXT(a_start_at_first, cmd.load, cmd.mult && (stage_idx == '0), "bad first stage")

endmodule
